// ----- rtl/core/hrfu_pkg.sv -----
// ----------------------------------------------------------------------------
// hrfu_pkg
// Shared types and constants for the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package hrfu_pkg;

    localparam int MAX_RTP_PAYLOAD_DEF = 1400;
    localparam int RTP_HDR_BYTES       = 12;
    localparam int FU_HDR_BYTES        = 2;
    localparam int QUEUE_DEPTH         = 2;
    localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

    localparam logic [4:0]  FU_A_TYPE     = 5'd28;
    localparam logic [31:0] TS_STEP_RESET = 32'd3600;

    typedef enum logic [1:0] {
        CFG_SEQ_START = 2'd0,
        CFG_TS_START  = 2'd1,
        CFG_TS_STEP   = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_bk_state;

    typedef struct packed {
        logic [7:0]  nal_header;
        logic [15:0] nal_length;
    } t_nal_in;

    typedef struct packed {
        logic [15:0] seq_number;
        logic [31:0] timestamp;
        logic        marker;
        logic        fragmented;
        logic [7:0]  fu_ind_byte;
        logic [7:0]  fu_hdr_byte;
        logic [15:0] payload_offset;
        logic [10:0] payload_length;
        logic [10:0] packet_length;
        logic        last;
    } t_pkt_out;

    typedef struct packed {
        logic [7:0]  hdr;
        logic [15:0] len;
        logic        frag;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic        valid;
        t_cfg_idx    index;
        logic [31:0] data;
    } t_cfg_wr;

endpackage

// ----- rtl/core/hrfu_front.sv -----
// ----------------------------------------------------------------------------
// hrfu_front
// Accepts NAL descriptors, drops empty ones and classifies single vs FU-A.
// ----------------------------------------------------------------------------
module hrfu_front
    import hrfu_pkg::*;
#(
    parameter int MAX_RTP_PAYLOAD = MAX_RTP_PAYLOAD_DEF
) (
    input  logic    i_valid,
    input  t_nal_in i_nal,
    output logic    o_stall,
    input  logic    i_full,
    output t_push   o_push
);

    localparam int SingleMax = MAX_RTP_PAYLOAD - RTP_HDR_BYTES;

    assign o_stall = i_full;

    always_comb begin
        o_push.valid    = i_valid && !i_full && (i_nal.nal_length != 16'd0);
        o_push.job.hdr  = i_nal.nal_header;
        o_push.job.len  = i_nal.nal_length;
        o_push.job.frag = (i_nal.nal_length > 16'(SingleMax));
    end

endmodule

// ----- rtl/core/hrfu_queue.sv -----
// ----------------------------------------------------------------------------
// hrfu_queue
// Short job queue between the classifier and the packet sequencer.
// ----------------------------------------------------------------------------
module hrfu_queue
    import hrfu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_job  o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;

    logic do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(i_push.valid) - (QUEUE_AW+1)'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule

// ----- rtl/core/hrfu_back.sv -----
// ----------------------------------------------------------------------------
// hrfu_back
// Packet sequencer: emits one RTP packet descriptor per cycle for each job while the output is not stalled.
// ----------------------------------------------------------------------------
module hrfu_back
    import hrfu_pkg::*;
#(
    parameter int MAX_RTP_PAYLOAD = MAX_RTP_PAYLOAD_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    input  logic     i_empty,
    input  t_job     i_job,
    output logic     o_pop,
    output logic     o_valid,
    output t_pkt_out o_pkt,
    input  logic     i_stall
);

    localparam int FragSize = MAX_RTP_PAYLOAD - RTP_HDR_BYTES - FU_HDR_BYTES;

    t_bk_state   r_state, n_state;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_ts, n_ts;
    logic [31:0] r_step, n_step;
    logic [15:0] r_left, n_left;
    logic [15:0] r_off, n_off;
    logic [7:0]  r_hdr, n_hdr;
    logic        r_single, n_single;
    logic        r_first, n_first;
    logic        r_out_valid, n_out_valid;
    t_pkt_out    r_out, n_out;

    logic        ld;
    logic        emit;
    logic        fin;
    logic [10:0] chunk;

    assign ld    = !r_out_valid || !i_stall;
    assign emit  = (r_state == BK_RUN) && ld;
    assign fin   = r_single || (r_left <= 16'(FragSize));
    assign chunk = fin ? r_left[10:0] : 11'(FragSize);

    always_comb begin
        n_state     = r_state;
        n_seq       = r_seq;
        n_ts        = r_ts;
        n_step      = r_step;
        n_left      = r_left;
        n_off       = r_off;
        n_hdr       = r_hdr;
        n_single    = r_single;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        o_pop       = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_hdr    = i_job.hdr;
                    n_single = !i_job.frag;
                    n_first  = 1'b1;
                    n_left   = i_job.frag ? i_job.len - 16'd1 : i_job.len;
                    n_off    = i_job.frag ? 16'd1 : 16'd0;
                    n_state  = BK_RUN;
                end
            end
            BK_RUN: begin
                if (emit) begin
                    n_out_valid          = 1'b1;
                    n_out.seq_number     = r_seq;
                    n_out.timestamp      = r_ts;
                    n_out.marker         = fin;
                    n_out.fragmented     = !r_single;
                    n_out.fu_ind_byte    = r_single ? 8'd0 : {r_hdr[7:5], FU_A_TYPE};
                    n_out.fu_hdr_byte    = r_single ? 8'd0
                                                    : {r_first, fin, 1'b0, r_hdr[4:0]};
                    n_out.payload_offset = r_off;
                    n_out.payload_length = chunk;
                    n_out.packet_length  = chunk + (r_single ? 11'(RTP_HDR_BYTES)
                                                    : 11'(RTP_HDR_BYTES + FU_HDR_BYTES));
                    n_out.last           = fin;
                    n_seq   = r_seq + 16'd1;
                    n_left  = r_left - {5'd0, chunk};
                    n_off   = r_off + {5'd0, chunk};
                    n_first = 1'b0;
                    if (fin) begin
                        n_ts    = r_ts + r_step;
                        n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SEQ_START: n_seq  = i_cfg.data[15:0];
                CFG_TS_START:  n_ts   = i_cfg.data;
                CFG_TS_STEP:   n_step = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_seq       <= '0;
            r_ts        <= '0;
            r_step      <= TS_STEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seq       <= n_seq;
            r_ts        <= n_ts;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_off    <= n_off;
        r_hdr    <= n_hdr;
        r_single <= n_single;
        r_first  <= n_first;
        r_out    <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_pkt   = r_out;

    a_run_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RUN) |-> (r_left != 16'd0))
        else $error("sequencer running with no bytes left");

    a_final_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && fin) |=> (r_state == BK_IDLE))
        else $error("sequencer did not return to idle after final packet");

    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !i_cfg.valid) |=> (r_seq == 16'($past(r_seq) + 16'd1)))
        else $error("sequence number did not advance on emitted packet");

endmodule

// ----- rtl/core/h264_rtp_fua_packetizer_unit.sv -----
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_unit
// H.264 RTP packetizer (single-NAL and FU-A) at descriptor level.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one NAL descriptor
// (header byte, length). Output channel (o_out_valid / i_out_stall /
// o_out_data) returns one RTP packet descriptor per packet. A NAL that fits in
// MAX_RTP_PAYLOAD-12 bytes yields one single-NAL packet; a longer one yields
// FU-A fragments of at most MAX_RTP_PAYLOAD-14 bytes. Zero-length NALs are dropped.
// The config channel (i_cfg_valid / o_cfg_ready) is always ready and loads
// the sequence start, timestamp start and timestamp step; write it only idle.
// A taken request is written into the queue, then fetched by the idle
// sequencer; each packet is registered in the output register. Unless the
// output stalls, the sequencer emits one packet per cycle, with a fetch step
// per NAL; a two-entry queue lets input requests be taken while packets drain.
// Reset clears sequence and timestamp to zero and the step to 3600. A stall
// on a valid output holds the output register and stops packet emission.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_unit
    import hrfu_pkg::*;
#(
    parameter int MAX_RTP_PAYLOAD = MAX_RTP_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_nal_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_pkt_out    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_push   push;
    t_job    job;
    t_cfg_wr cfg;
    logic    full;
    logic    empty;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg.valid = i_cfg_valid;
        cfg.index = t_cfg_idx'(i_cfg_index);
        cfg.data  = i_cfg_data;
    end

    hrfu_front #(
        .MAX_RTP_PAYLOAD (MAX_RTP_PAYLOAD)
    ) u_front (
        .i_valid (i_in_valid),
        .i_nal   (i_in_data),
        .o_stall (o_in_stall),
        .i_full  (full),
        .o_push  (push)
    );

    hrfu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job)
    );

    hrfu_back #(
        .MAX_RTP_PAYLOAD (MAX_RTP_PAYLOAD)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_job   (job),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_pkt   (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
